/* rtl/lkc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_pkg: shared types and constants for the LRU key cache tracker
// Field widths, sequencer states and the result word layout.
// ----------------------------------------------------------------------------
package lkc_pkg;

  localparam int LKC_CAPACITY = 16;

  localparam int KEY_W  = 32;
  localparam int SLOT_W = 4;
  localparam int SIZE_W = 5;

  localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

  localparam logic KIND_LOOKUP = 1'b0;
  localparam logic KIND_STORE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_AGE,
    ST_EV_SCAN,
    ST_EV_READ,
    ST_EV_EMIT,
    ST_INSERT,
    ST_FINAL
  } state_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic [SLOT_W-1:0] evicted_slot;
    logic              last;
  } res_t;

endpackage

/* rtl/lkc_keymem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_keymem: key storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lkc_keymem
  import lkc_pkg::*;
#(
  parameter int DEPTH = LKC_CAPACITY,
  parameter int AW    = $clog2(LKC_CAPACITY)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [KEY_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [KEY_W-1:0] rd_data
);

  logic [KEY_W-1:0] mem_r [DEPTH];
  logic [KEY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/lkc_outreg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_outreg: result output register
// Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module lkc_outreg
  import lkc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  res_t              res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_evicted,
  output logic [KEY_W-1:0]  out_evicted_key,
  output logic [SLOT_W-1:0] out_evicted_slot,
  output logic              out_last
);

  logic out_valid_r;
  logic out_valid_nxt;
  res_t res_r;

  // register can take a new word when empty or being drained this cycle
  assign free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = res_r.hit;
  assign out_slot         = res_r.slot;
  assign out_evicted      = res_r.evicted;
  assign out_evicted_key  = res_r.evicted_key;
  assign out_evicted_slot = res_r.evicted_slot;
  assign out_last         = res_r.last;

endmodule

/* rtl/lkc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_ctrl: sequencer and entry state
// Search, age, victim scan: one entry per cycle, evictions pausing; insert.
// ----------------------------------------------------------------------------
module lkc_ctrl
  import lkc_pkg::*;
#(
  parameter int CAPACITY = LKC_CAPACITY,
  parameter int IDX_W    = $clog2(LKC_CAPACITY),
  parameter int CNT_W    = $clog2(LKC_CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [SIZE_W-1:0] store_size,
  input  logic              out_free,
  output logic              res_load,
  output res_t              res,
  output logic              mem_wr_en,
  output logic [IDX_W-1:0]  mem_wr_addr,
  output logic [KEY_W-1:0]  mem_wr_data,
  output logic [IDX_W-1:0]  mem_rd_addr,
  input  logic [KEY_W-1:0]  mem_rd_data
);

  localparam int LW = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                kind_r, kind_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic                hit_r, hit_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [IDX_W-1:0]    rref_r, rref_nxt;
  logic                age_all_r, age_all_nxt;
  logic [IDX_W-1:0]    free_r, free_nxt;
  logic                free_found_r, free_found_nxt;
  logic [IDX_W-1:0]    victim_r, victim_nxt;
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [IDX_W-1:0]    rank_r   [CAPACITY];
  logic [IDX_W-1:0]    rank_nxt [CAPACITY];
  logic [CNT_W-1:0]    count_r, count_nxt;

  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] cnt_dec;
  logic [IDX_W-1:0] srch_idx;
  logic             scan_last;
  logic             search_done;
  logic             match;
  logic             hit_now;
  logic [LW-1:0]    sz_ext;
  logic [LW-1:0]    eff;
  logic [LW-1:0]    limit;
  logic             over;
  logic             victim_hit;
  logic             age_hit;

  assign idx         = cnt_r[IDX_W-1:0];
  assign cnt_dec     = cnt_r - 1'b1;
  assign srch_idx    = cnt_dec[IDX_W-1:0];
  assign scan_last   = (cnt_r == CNT_W'(CAPACITY - 1));
  assign search_done = (cnt_r == CNT_W'(CAPACITY));

  // read data is registered, so it belongs to the previous scan address
  assign match   = (cnt_r != '0) && valid_r[srch_idx] && (mem_rd_data == key_r);
  assign hit_now = hit_r || match;

  assign sz_ext = LW'(store_size);
  assign eff    = (sz_ext == '0) ? LW'(1) :
                  (sz_ext > LW'(CAPACITY)) ? LW'(CAPACITY) : sz_ext;
  // a new key needs room for itself
  assign limit  = hit_r ? eff : eff - 1'b1;
  assign over   = (LW'(count_r) > limit);

  assign victim_hit = valid_r[idx] && (CNT_W'(rank_r[idx]) == count_r - 1'b1);
  assign age_hit    = valid_r[idx] && (age_all_r || (rank_r[idx] < rref_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (search_done) begin
          if (hit_now) state_nxt = ST_AGE;
          else if (kind_r == KIND_STORE) state_nxt = ST_EV_SCAN;
          else state_nxt = ST_FINAL;
        end
      end
      ST_AGE: begin
        if (scan_last) begin
          if (age_all_r) state_nxt = ST_INSERT;
          else if (kind_r == KIND_STORE) state_nxt = ST_EV_SCAN;
          else state_nxt = ST_FINAL;
        end
      end
      ST_EV_SCAN: begin
        if (!over || (!victim_hit && scan_last)) begin
          state_nxt = hit_r ? ST_FINAL : ST_AGE;
        end else if (victim_hit) begin
          state_nxt = ST_EV_READ;
        end
      end
      ST_EV_READ: begin
        state_nxt = ST_EV_EMIT;
      end
      ST_EV_EMIT: begin
        if (out_free) state_nxt = ST_EV_SCAN;
      end
      ST_INSERT: begin
        state_nxt = ST_FINAL;
      end
      ST_FINAL: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    res_load    = 1'b0;
    res         = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = free_r;
    mem_wr_data = key_r;
    mem_rd_addr = search_done ? '0 : idx;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EV_READ: begin
        mem_rd_addr = victim_r;
      end
      ST_EV_EMIT: begin
        mem_rd_addr      = victim_r;
        res_load         = out_free;
        res.evicted      = 1'b1;
        res.evicted_key  = mem_rd_data;
        res.evicted_slot = SLOT_W'(victim_r);
      end
      ST_INSERT: begin
        mem_wr_en = 1'b1;
      end
      ST_FINAL: begin
        res_load = out_free;
        res.hit  = hit_r;
        res.slot = (hit_r || (kind_r == KIND_STORE)) ? SLOT_W'(pos_r) : '0;
        res.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // datapath and entry state
  always_comb begin
    cnt_nxt        = (state_nxt != state_r) ? '0 : cnt_r + 1'b1;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    hit_nxt        = hit_r;
    pos_nxt        = pos_r;
    rref_nxt       = rref_r;
    age_all_nxt    = age_all_r;
    free_nxt       = free_r;
    free_found_nxt = free_found_r;
    victim_nxt     = victim_r;
    valid_nxt      = valid_r;
    rank_nxt       = rank_r;
    count_nxt      = count_r;

    if (state_nxt == ST_AGE && state_r != ST_AGE) begin
      age_all_nxt    = (state_r == ST_EV_SCAN);
      free_found_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          key_nxt  = in_key;
          hit_nxt  = 1'b0;
        end
      end
      ST_SEARCH: begin
        if (match && !hit_r) begin
          hit_nxt  = 1'b1;
          pos_nxt  = srch_idx;
          rref_nxt = rank_r[srch_idx];
        end
      end
      ST_AGE: begin
        if (age_hit) rank_nxt[idx] = rank_r[idx] + 1'b1;
        if (!valid_r[idx] && !free_found_r) begin
          free_nxt       = idx;
          free_found_nxt = 1'b1;
        end
        if (scan_last && !age_all_r) rank_nxt[pos_r] = '0;
      end
      ST_EV_SCAN: begin
        if (over && victim_hit) victim_nxt = idx;
      end
      ST_EV_EMIT: begin
        if (out_free) begin
          valid_nxt[victim_r] = 1'b0;
          rank_nxt[victim_r]  = '0;
          count_nxt           = count_r - 1'b1;
        end
      end
      ST_INSERT: begin
        valid_nxt[free_r] = 1'b1;
        rank_nxt[free_r]  = '0;
        count_nxt         = count_r + 1'b1;
        pos_nxt           = free_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      valid_r <= '0;
      rank_r  <= '{default: '0};
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    hit_r        <= hit_nxt;
    pos_r        <= pos_nxt;
    rref_r       <= rref_nxt;
    age_all_r    <= age_all_nxt;
    free_r       <= free_nxt;
    free_found_r <= free_found_nxt;
    victim_r     <= victim_nxt;
  end

endmodule

/* rtl/lru_key_cache_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_cache_tracker: LRU tracker for 32-bit content keys
// Lookup/refresh and store with oldest-first eviction reports.
// ----------------------------------------------------------------------------
// Takes one word at a time and drops in_ready until its last result word is
// loaded. Each pass walks the CAPACITY entries one per cycle through a single
// compare/increment unit and the one read port of the key memory, so time
// scales with CAPACITY: a lookup miss takes one search pass, a lookup hit a
// search pass plus a recency pass, a store hit adds a victim scan, and a new
// store runs search, victim scan, aging and insertion. Each eviction pauses
// the victim scan for a key read and a report. Output stalls add directly. A new
// store_size is applied at the next victim scan; lookups never evict.
// ----------------------------------------------------------------------------
module lru_key_cache_tracker
  import lkc_pkg::*;
#(
  parameter int CAPACITY = LKC_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [KEY_W-1:0]  in_key,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit,
  output logic [SLOT_W-1:0] out_slot,
  output logic              out_evicted,
  output logic [KEY_W-1:0]  out_evicted_key,
  output logic [SLOT_W-1:0] out_evicted_slot,
  output logic              out_last
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [SIZE_W-1:0] store_size_r;
  logic [SIZE_W-1:0] store_size_nxt;

  logic              out_free;
  logic              res_load;
  res_t              res;
  logic              mem_wr_en;
  logic [IDX_W-1:0]  mem_wr_addr;
  logic [KEY_W-1:0]  mem_wr_data;
  logic [IDX_W-1:0]  mem_rd_addr;
  logic [KEY_W-1:0]  mem_rd_data;

  assign store_size_nxt = cfg_wr_en ? cfg_wr_data : store_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_size_r <= SIZE_RST;
    end else begin
      store_size_r <= store_size_nxt;
    end
  end

  lkc_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_key      (in_key),
    .store_size  (store_size_r),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  lkc_keymem #(
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_keymem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  lkc_outreg u_outreg (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (res_load),
    .res              (res),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_slot         (out_slot),
    .out_evicted      (out_evicted),
    .out_evicted_key  (out_evicted_key),
    .out_evicted_slot (out_evicted_slot),
    .out_last         (out_last)
  );

endmodule

/* rtl/lkc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkc_checker: port-level checks for the LRU key cache tracker
// Result word framing and busy behavior, bound to the top level.
// ----------------------------------------------------------------------------
module lkc_checker
  import lkc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_hit,
  input logic [SLOT_W-1:0] out_slot,
  input logic              out_evicted,
  input logic [KEY_W-1:0]  out_evicted_key,
  input logic [SLOT_W-1:0] out_evicted_slot,
  input logic              out_last
);

  // a pending word holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_evicted_key)
      && $stable(out_last) && $stable(out_slot))
    else $error("result word changed while stalled");

  // every word is either an eviction report or the closing word
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last != out_evicted))
    else $error("result word is neither eviction nor final");

  a_evict_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit && (out_slot == '0))
    else $error("eviction word carries hit or slot");

  a_final_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> (out_evicted_key == '0) && (out_evicted_slot == '0))
    else $error("final word carries eviction data");

  // an accepted word keeps the block busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in progress");

endmodule

bind lru_key_cache_tracker lkc_checker u_lkc_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lru_key_cache_tracker
// A shadow LRU table predicts every result word (evictions oldest first, then
// the final word) for each accepted input word. Lookups and stores come
// directed first, then as random phases over several store sizes. Random
// gaps on both channels, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------

class lru_scoreboard;
  localparam int NSLOT = lkc_pkg::LKC_CAPACITY;

  logic [31:0] slot_key [NSLOT];
  bit          slot_used [NSLOT];
  int          slot_age [NSLOT];
  int          used_count;
  logic [4:0]  size_reg;
  lkc_pkg::res_t due_words [$];

  int errors;
  int items;
  int words_seen;
  int evictions;
  int hits;

  function new();
    foreach (slot_key[i]) begin
      slot_key[i]  = '0;
      slot_used[i] = 1'b0;
      slot_age[i]  = 0;
    end
    used_count = 0;
    size_reg   = lkc_pkg::SIZE_RST;
    errors     = 0;
    items      = 0;
    words_seen = 0;
    evictions  = 0;
    hits       = 0;
  endfunction

  function void set_size(logic [4:0] v);
    size_reg = v;
  endfunction

  // size 0 acts as 1, anything above capacity saturates
  function int limit_size();
    int s;
    s = size_reg;
    if (s < 1) s = 1;
    if (s > NSLOT) s = NSLOT;
    return s;
  endfunction

  function int find_slot(logic [31:0] key);
    for (int i = 0; i < NSLOT; i++)
      if (slot_used[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  function void make_newest(int s);
    int r;
    r = slot_age[s];
    for (int i = 0; i < NSLOT; i++)
      if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function void push_word(bit hit, int slot, bit ev, logic [31:0] ekey, int eslot, bit last);
    lkc_pkg::res_t w;
    w.hit          = hit;
    w.slot         = slot[3:0];
    w.evicted      = ev;
    w.evicted_key  = ekey;
    w.evicted_slot = eslot[3:0];
    w.last         = last;
    due_words.push_back(w);
  endfunction

  // drop oldest entries until the count fits under lim
  function void evict_over(int lim);
    int victim;
    while (used_count > lim) begin
      victim = -1;
      for (int i = 0; i < NSLOT; i++)
        if (victim < 0 && slot_used[i] && slot_age[i] == used_count - 1) victim = i;
      if (victim < 0) break;
      slot_used[victim] = 1'b0;
      slot_age[victim]  = 0;
      used_count--;
      push_word(1'b0, 0, 1'b1, slot_key[victim], victim, 1'b0);
    end
  endfunction

  function void note_item(logic kind, logic [31:0] key);
    int pos;
    int free_slot;
    pos = find_slot(key);
    items++;
    if (kind == lkc_pkg::KIND_LOOKUP) begin
      if (pos >= 0) begin
        make_newest(pos);
        push_word(1'b1, pos, 1'b0, '0, 0, 1'b1);
      end else begin
        push_word(1'b0, 0, 1'b0, '0, 0, 1'b1);
      end
    end else if (pos >= 0) begin
      make_newest(pos);
      evict_over(limit_size());
      push_word(1'b1, pos, 1'b0, '0, 0, 1'b1);
    end else begin
      evict_over(limit_size() - 1);
      free_slot = -1;
      for (int i = 0; i < NSLOT; i++)
        if (free_slot < 0 && !slot_used[i]) free_slot = i;
      if (free_slot < 0) free_slot = 0;
      for (int i = 0; i < NSLOT; i++)
        if (slot_used[i]) slot_age[i]++;
      slot_key[free_slot]  = key;
      slot_used[free_slot] = 1'b1;
      slot_age[free_slot]  = 0;
      used_count++;
      push_word(1'b0, free_slot, 1'b0, '0, 0, 1'b1);
    end
  endfunction

  function void field_check(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s differs, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endfunction

  function void check_word(lkc_pkg::res_t got);
    lkc_pkg::res_t e;
    words_seen++;
    if (due_words.size() == 0) begin
      errors++;
      $display("%0t: result word with nothing expected, got %0h", $time, got);
      return;
    end
    e = due_words[0];
    due_words.delete(0);
    if (e.evicted) evictions++;
    if (e.hit) hits++;
    field_check("hit", 32'(e.hit), 32'(got.hit));
    field_check("slot", 32'(e.slot), 32'(got.slot));
    field_check("evicted", 32'(e.evicted), 32'(got.evicted));
    field_check("evicted_key", e.evicted_key, got.evicted_key);
    field_check("evicted_slot", 32'(e.evicted_slot), 32'(got.evicted_slot));
    field_check("last", 32'(e.last), 32'(got.last));
  endfunction

  function int pending();
    return due_words.size();
  endfunction
endclass

module testbench;
  import lkc_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 39;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_kind = KIND_LOOKUP;
  logic [KEY_W-1:0]  in_key = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_hit;
  logic [SLOT_W-1:0] out_slot;
  logic              out_evicted;
  logic [KEY_W-1:0]  out_evicted_key;
  logic [SLOT_W-1:0] out_evicted_slot;
  logic              out_last;

  lru_scoreboard sb = new();
  bit  hold_req  = 1'b0;
  bit  no_gaps   = 1'b0;
  int  cycles    = 0;
  int  size_sets = 0;

  lru_key_cache_tracker u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_key           (in_key),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_slot         (out_slot),
    .out_evicted      (out_evicted),
    .out_evicted_key  (out_evicted_key),
    .out_evicted_slot (out_evicted_slot),
    .out_last         (out_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, sb.pending());
      $display("lru_key_cache_tracker: mismatch");
      $finish;
    end
  end

  // results first: a word leaving this edge never belongs to a word entering it
  always @(posedge clk) begin
    res_t got;
    if (rst_n && out_valid && out_ready) begin
      got.hit          = out_hit;
      got.slot         = out_slot;
      got.evicted      = out_evicted;
      got.evicted_key  = out_evicted_key;
      got.evicted_slot = out_evicted_slot;
      got.last         = out_last;
      sb.check_word(got);
    end
    if (rst_n && in_valid && in_ready) sb.note_item(in_kind, in_key);
  end

  // output side: random ready pattern, with one long hold-off on request
  initial begin
    int pick;
    wait (rst_n);
    @(posedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (pick < 55) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else if (pick < 65) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(40, 150)) @(posedge clk);
      end else if (pick < 93) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(15, 50)) @(posedge clk);
      end
    end
  end

  // leaves valid high; the caller lowers it only for a real gap
  task automatic send_word(input logic kind, input logic [KEY_W-1:0] key);
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_key   <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    n = 0;
    if (!no_gaps) begin
      if (pick >= 90) n = $urandom_range(10, 40);
      else if (pick >= 60) n = $urandom_range(1, 3);
    end
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_size(v);
    size_sets++;
    @(posedge clk);
  endtask

  task automatic directed_items();
    send_word(KIND_LOOKUP, 32'h0000_0000);    // lookup on an empty table
    send_word(KIND_STORE,  32'h0000_0000);
    send_word(KIND_STORE,  32'hFFFF_FFFF);
    send_word(KIND_LOOKUP, 32'h0000_0000);
    send_word(KIND_LOOKUP, 32'hFFFF_FFFF);
    send_word(KIND_STORE,  32'h0000_0000);    // store of a present key: refresh only
    send_word(KIND_LOOKUP, 32'h1234_5678);
    for (int i = 0; i < 14; i++) send_word(KIND_STORE, $urandom);
    send_word(KIND_STORE, 32'hA5A5_5A5A);     // table full: one eviction
    write_size(5'd1);
    send_word(KIND_LOOKUP, 32'hA5A5_5A5A);    // shrunk, but lookups never evict
    send_word(KIND_STORE, 32'h5A5A_A5A5);     // evicts every entry before inserting
    write_size(5'd0);                          // zero acts as one
    send_word(KIND_STORE, 32'h0F0F_F0F0);
    send_word(KIND_STORE, 32'h0F0F_F0F0);
    write_size(5'd31);                         // saturates at capacity
    for (int i = 0; i < 3; i++) send_word(KIND_STORE, $urandom);
    write_size(5'd2);
    send_word(KIND_STORE, 32'h0F0F_F0F0);     // store hit that also evicts
  endtask

  task automatic random_phase(input int phase, input logic [SIZE_W-1:0] size_v);
    logic [KEY_W-1:0] pool [24];
    int pool_n;
    int burst;
    logic kind;
    logic [KEY_W-1:0] key;
    write_size(size_v);
    pool_n = $urandom_range(4, 24);
    foreach (pool[i]) pool[i] = $urandom;
    if (phase % 3 == 0) pool[0] = 32'hFFFF_FFFF;
    if (phase % 3 == 1) pool[0] = 32'h0000_0000;
    no_gaps = (phase == 2 || phase == 8);
    burst = 0;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (phase == 4 && n == 10) begin
        hold_req = 1'b1;
        burst = 10;
      end
      if (phase == 7 && n == 20) wait_drained();
      if ($urandom_range(0, 99) < 10) begin
        key  = $urandom;
        kind = 1'($urandom_range(0, 1));
      end else begin
        key  = pool[$urandom_range(0, pool_n - 1)];
        kind = ($urandom_range(0, 99) < 55) ? KIND_STORE : KIND_LOOKUP;
      end
      send_word(kind, key);
      if (burst > 0) burst--;
      else sender_gap();
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes [PHASES];
    sizes = '{5'd16, 5'd3, 5'd8, 5'd1, 5'd31, 5'd0, 5'd5, 5'd12, 5'd2, 5'd16};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    for (int p = 0; p < PHASES; p++) random_phase(p, sizes[p]);
    wait_drained();
    repeat (40) @(posedge clk);
    $display("ran %0d words over %0d size settings, lookups and stores",
             sb.items, size_sets);
    $display("checked %0d result words: %0d evictions, %0d hits",
             sb.words_seen, sb.evictions, sb.hits);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("lru_key_cache_tracker: match");
    end else begin
      $display("lru_key_cache_tracker: mismatch");
    end
    $finish;
  end

endmodule
